// ----- src/dca_pkg.sv -----
// dca_pkg: operation codes and controller/datapath handshake types
// for the dma channel allocator; no dependencies
package dca_pkg;

   localparam int OP_W  = 3;
   localparam int CH_W  = 6;
   localparam int RCH_W = 5;
   localparam int SEQ_W = 32;
   localparam int PEND_W = 32;

   localparam logic [OP_W-1:0] OP_ALLOC_ANY      = 3'd0;
   localparam logic [OP_W-1:0] OP_ALLOC_SPECIFIC = 3'd1;
   localparam logic [OP_W-1:0] OP_FREE           = 3'd2;
   localparam logic [OP_W-1:0] OP_QUERY          = 3'd3;
   localparam logic [OP_W-1:0] OP_SET_HANDLER    = 3'd4;
   localparam logic [OP_W-1:0] OP_INTERRUPT      = 3'd5;

   // commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic exec;
      logic dispatch;
   } dca_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic work_empty;
      logic work_last;
   } dca_status_type;

endpackage

// ----- src/dca_ctrl.sv -----
// dca_ctrl: sequencing state machine of the channel allocator
// depends on dca_pkg
module dca_ctrl
   import dca_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [OP_W-1:0]   req_operation,
   input  dca_status_type    status,
   output dca_cmd_type       cmd,
   output logic              busy
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = (req_operation == OP_INTERRUPT) ? S_SCAN : S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_IDLE;
         end
         S_SCAN: begin
            if (status.work_empty) begin
               state_in = S_IDLE;
            end else begin
               cmd.dispatch = 1'b1;
               if (status.work_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ----- src/dca_datapath.sv -----
// dca_datapath: allocation bitmap, next-fit pointer, handler flags,
// sequence counters and result registers; depends on dca_pkg
module dca_datapath
   import dca_pkg::*;
#(
   parameter int CHANNELS = 8
)
(
   input  logic                clock,
   input  logic                reset,
   input  dca_cmd_type         cmd,
   output dca_status_type      status,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [CH_W-1:0]     req_channel,
   input  logic                req_handler_present,
   input  logic [PEND_W-1:0]   req_pending_mask,
   output logic                rsp_strobe,
   output logic                rsp_ok,
   output logic [RCH_W-1:0]    rsp_result_channel,
   output logic [SEQ_W-1:0]    rsp_sequence_res,
   output logic                rsp_is_dispatch,
   output logic                rsp_last
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);
   localparam logic [CH_W:0]    CH_LIMIT = (CH_W + 1)'(CHANNELS);

   // latched request
   logic [OP_W-1:0]      op_ff;
   logic [CH_W-1:0]      chan_ff;
   logic                 hp_ff;

   // allocator state
   logic [CHANNELS-1:0]  alloc_ff,  alloc_in;
   logic [IDX_W-1:0]     ptr_ff,    ptr_in;
   logic [CHANNELS-1:0]  hflag_ff,  hflag_in;
   logic [SEQ_W-1:0]     seq_ff [CHANNELS];
   logic [SEQ_W-1:0]     seq_in [CHANNELS];
   logic [CHANNELS-1:0]  work_ff,   work_in;

   // result registers
   logic                 strobe_ff, strobe_in;
   logic                 ok_ff,     ok_in;
   logic [RCH_W-1:0]     rch_ff,    rch_in;
   logic [SEQ_W-1:0]     seqr_ff,   seqr_in;
   logic                 disp_ff,   disp_in;
   logic                 last_ff,   last_in;

   logic                 chan_valid;
   logic [IDX_W-1:0]     cidx;
   logic [CHANNELS-1:0]  free_bits;
   logic [IDX_W-1:0]     first_any, first_hi, scan_idx;
   logic                 found_hi;
   logic [CHANNELS-1:0]  work_rest;
   logic                 claim_en;
   logic [IDX_W-1:0]     claim_idx;

   assign chan_valid = ({1'b0, chan_ff} < CH_LIMIT);
   assign cidx       = chan_ff[IDX_W-1:0];
   assign free_bits  = ~alloc_ff;
   assign work_rest  = work_ff & (work_ff - 1'b1);

   // round-robin search from the pointer, and lowest pending channel
   always_comb begin
      first_any = '0;
      first_hi  = '0;
      found_hi  = 1'b0;
      scan_idx  = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            first_any = IDX_W'(i);
         end
         if (free_bits[i] && (IDX_W'(i) >= ptr_ff)) begin
            first_hi = IDX_W'(i);
            found_hi = 1'b1;
         end
         if (work_ff[i]) begin
            scan_idx = IDX_W'(i);
         end
      end
   end

   assign status.work_empty = (work_ff == '0);
   assign status.work_last  = (work_rest == '0);

   always_comb begin
      alloc_in  = alloc_ff;
      ptr_in    = ptr_ff;
      hflag_in  = hflag_ff;
      seq_in    = seq_ff;
      work_in   = work_ff;
      strobe_in = 1'b0;
      ok_in     = 1'b0;
      rch_in    = '0;
      seqr_in   = '0;
      disp_in   = 1'b0;
      last_in   = 1'b0;
      claim_en  = 1'b0;
      claim_idx = '0;

      if (cmd.accept) begin
         work_in = req_pending_mask[CHANNELS-1:0] & hflag_ff;
      end

      if (cmd.exec) begin
         strobe_in = 1'b1;
         last_in   = 1'b1;
         unique case (op_ff)
            OP_ALLOC_ANY: begin
               if (free_bits != '0) begin
                  claim_en  = 1'b1;
                  claim_idx = found_hi ? first_hi : first_any;
               end
            end
            OP_ALLOC_SPECIFIC: begin
               if (chan_valid && !alloc_ff[cidx]) begin
                  claim_en  = 1'b1;
                  claim_idx = cidx;
               end
            end
            OP_FREE: begin
               ok_in = chan_valid;
               if (chan_valid) begin
                  alloc_in[cidx] = 1'b0;
                  hflag_in[cidx] = 1'b0;
                  seq_in[cidx]   = '0;
               end
            end
            OP_QUERY: begin
               ok_in = chan_valid && alloc_ff[cidx];
            end
            OP_SET_HANDLER: begin
               ok_in = chan_valid;
               if (chan_valid) begin
                  hflag_in[cidx] = hp_ff;
                  seq_in[cidx]   = '0;
               end
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
         if (claim_en) begin
            alloc_in[claim_idx] = 1'b1;
            ptr_in = (claim_idx == LAST_IDX) ? '0 : claim_idx + 1'b1;
            ok_in  = 1'b1;
            rch_in = RCH_W'(claim_idx);
         end
      end

      if (cmd.dispatch) begin
         strobe_in        = 1'b1;
         ok_in            = 1'b1;
         disp_in          = 1'b1;
         rch_in           = RCH_W'(scan_idx);
         seqr_in          = seq_ff[scan_idx];
         last_in          = (work_rest == '0);
         seq_in[scan_idx] = seq_ff[scan_idx] + 1'b1;
         work_in          = work_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_operation;
         chan_ff <= req_channel;
         hp_ff   <= req_handler_present;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff  <= '0;
         ptr_ff    <= '0;
         hflag_ff  <= '0;
         seq_ff    <= '{default: '0};
         work_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         alloc_ff  <= alloc_in;
         ptr_ff    <= ptr_in;
         hflag_ff  <= hflag_in;
         seq_ff    <= seq_in;
         work_ff   <= work_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff   <= ok_in;
      rch_ff  <= rch_in;
      seqr_ff <= seqr_in;
      disp_ff <= disp_in;
      last_ff <= last_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_ok             = ok_ff;
   assign rsp_result_channel = rch_ff;
   assign rsp_sequence_res   = seqr_ff;
   assign rsp_is_dispatch    = disp_ff;
   assign rsp_last           = last_ff;

endmodule

// ----- src/dma_channel_allocator.sv -----
// dma_channel_allocator: top level, controller plus datapath
// depends on dca_pkg, dca_ctrl, dca_datapath
//
// channel   ports                                          handshake
// request   req_operation req_channel req_handler_present  start high, busy low
//           req_pending_mask
// result    rsp_ok rsp_result_channel rsp_sequence_res     rsp_strobe, one cycle
//           rsp_is_dispatch rsp_last
//
// allocate, free, query and set handler: request taken, then a work state, result
// on the next cycle while busy is already low
// interrupt event: one dispatch result per cycle from the pending-channel scan;
// no result if none pend
// synchronous active-high reset clears bitmap, pointer, handler flags and counters
// results cannot be held off by the receiver
module dma_channel_allocator
   import dca_pkg::*;
#(
   parameter int CHANNELS = 8
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [CH_W-1:0]     req_channel,
   input  logic                req_handler_present,
   input  logic [PEND_W-1:0]   req_pending_mask,
   output logic                rsp_strobe,
   output logic                rsp_ok,
   output logic [RCH_W-1:0]    rsp_result_channel,
   output logic [SEQ_W-1:0]    rsp_sequence_res,
   output logic                rsp_is_dispatch,
   output logic                rsp_last
);

   dca_cmd_type    cmd;
   dca_status_type status;

   dca_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy)
   );

   dca_datapath #(
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_operation       (req_operation),
      .req_channel         (req_channel),
      .req_handler_present (req_handler_present),
      .req_pending_mask    (req_pending_mask),
      .rsp_strobe          (rsp_strobe),
      .rsp_ok              (rsp_ok),
      .rsp_result_channel  (rsp_result_channel),
      .rsp_sequence_res    (rsp_sequence_res),
      .rsp_is_dispatch     (rsp_is_dispatch),
      .rsp_last            (rsp_last)
   );

   // a taken request always occupies the block for the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request taken but block not busy");

   // the final result of a request leaves the block ready again
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> !busy)
      else $error("busy after final result");

   // only dispatches come in runs, everything else is a single result
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_is_dispatch |-> rsp_last)
      else $error("non-dispatch result without last");

   // a dispatch names an existing channel and reports success
   a_dispatch_chan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_is_dispatch |->
         rsp_ok && ({1'b0, rsp_result_channel} < (RCH_W + 1)'(CHANNELS)))
      else $error("dispatch on invalid channel");

endmodule

// ----- tb/sv/tb_dma_channel_allocator.sv -----
`timescale 1ns / 1ps
// tb_dma_channel_allocator: self-checking bench for the dma channel allocator,
// directed then random requests checked against a next-fit bitmap scoreboard
// depends on dca_pkg and dma_channel_allocator
module tb_dma_channel_allocator;
   import dca_pkg::*;

   localparam int NUM_CHANNELS   = 8;
   localparam int WATCHDOG_LIMIT = 200;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_REQUESTS = 182;

   localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

   typedef struct {
      logic              ok;
      logic [RCH_W-1:0]  chan;
      logic [SEQ_W-1:0]  seq;
      logic              disp;
      logic              last;
   } alloc_result_type;

   class alloc_scoreboard #(int N = 8);
      logic [N-1:0]      taken_map;
      int unsigned       next_ptr;
      logic              has_handler [N];
      logic [SEQ_W-1:0]  seq_count [N];
      alloc_result_type  pending_q [$];
      int                errors;

      function new();
         taken_map = '0;
         next_ptr  = 0;
         errors    = 0;
         for (int i = 0; i < N; i++) begin
            has_handler[i] = 1'b0;
            seq_count[i]   = '0;
         end
      endfunction

      function void push(logic ok, logic [RCH_W-1:0] chan, logic [SEQ_W-1:0] seq,
                         logic disp, logic last);
         alloc_result_type r;
         r.ok   = ok;
         r.chan = chan;
         r.seq  = seq;
         r.disp = disp;
         r.last = last;
         pending_q.push_back(r);
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [CH_W-1:0] ch, logic hp,
                                 logic [PEND_W-1:0] mask);
         bit          valid;
         bit          found;
         int unsigned c;
         int          dispatched;
         valid = ch < N;
         found = 1'b0;
         dispatched = 0;
         case (op)
            OP_ALLOC_ANY: begin
               for (int a = 0; a < N && !found; a++) begin
                  c = (next_ptr + a) % N;
                  if (!taken_map[c]) begin
                     found = 1'b1;
                     taken_map[c] = 1'b1;
                     next_ptr = (c + 1) % N;
                     push(1'b1, c[RCH_W-1:0], '0, 1'b0, 1'b1);
                  end
               end
               if (!found) push(1'b0, '0, '0, 1'b0, 1'b1);
            end
            OP_ALLOC_SPECIFIC: begin
               if (valid && !taken_map[ch]) begin
                  taken_map[ch] = 1'b1;
                  next_ptr = (ch + 1) % N;
                  push(1'b1, ch[RCH_W-1:0], '0, 1'b0, 1'b1);
               end else begin
                  push(1'b0, '0, '0, 1'b0, 1'b1);
               end
            end
            OP_FREE: begin
               if (valid) begin
                  taken_map[ch]   = 1'b0;
                  has_handler[ch] = 1'b0;
                  seq_count[ch]   = '0;
               end
               push(valid, '0, '0, 1'b0, 1'b1);
            end
            OP_QUERY: begin
               push(valid && taken_map[ch], '0, '0, 1'b0, 1'b1);
            end
            OP_SET_HANDLER: begin
               if (valid) begin
                  has_handler[ch] = hp;
                  seq_count[ch]   = '0;
               end
               push(valid, '0, '0, 1'b0, 1'b1);
            end
            OP_INTERRUPT: begin
               // ascending scan, pending bits beyond the channel count ignored
               for (int i = 0; i < N; i++) begin
                  if (mask[i] && has_handler[i]) begin
                     c = i;
                     push(1'b1, c[RCH_W-1:0], seq_count[i], 1'b1, 1'b0);
                     seq_count[i] = seq_count[i] + 1'b1;
                     dispatched++;
                  end
               end
               if (dispatched > 0) pending_q[pending_q.size()-1].last = 1'b1;
            end
            default: begin
               push(1'b0, '0, '0, 1'b0, 1'b1);
            end
         endcase
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic ok, logic [RCH_W-1:0] chan, logic [SEQ_W-1:0] seq,
                                 logic disp, logic last);
         alloc_result_type want;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result expected none actual ok %0h chan %0h seq %0h",
                     $time, ok, chan, seq);
            errors++;
         end else begin
            want = pending_q.pop_front();
            compare_field("ok", 32'(want.ok), 32'(ok));
            compare_field("result_channel", 32'(want.chan), 32'(chan));
            compare_field("sequence_res", want.seq, seq);
            compare_field("is_dispatch", 32'(want.disp), 32'(disp));
            compare_field("last", 32'(want.last), 32'(last));
         end
      endfunction
   endclass

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [OP_W-1:0]    req_operation = '0;
   logic [CH_W-1:0]    req_channel = '0;
   logic               req_handler_present = 1'b0;
   logic [PEND_W-1:0]  req_pending_mask = '0;
   logic               rsp_strobe;
   logic               rsp_ok;
   logic [RCH_W-1:0]   rsp_result_channel;
   logic [SEQ_W-1:0]   rsp_sequence_res;
   logic               rsp_is_dispatch;
   logic               rsp_last;

   logic               fired = 1'b0;
   logic               quiet = 1'b0;
   int                 idle_cycles = 0;

   alloc_scoreboard #(NUM_CHANNELS) board;

   dma_channel_allocator #(.CHANNELS(NUM_CHANNELS)) u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_channel         (req_channel),
      .req_handler_present (req_handler_present),
      .req_pending_mask    (req_pending_mask),
      .rsp_strobe          (rsp_strobe),
      .rsp_ok              (rsp_ok),
      .rsp_result_channel  (rsp_result_channel),
      .rsp_sequence_res    (rsp_sequence_res),
      .rsp_is_dispatch     (rsp_is_dispatch),
      .rsp_last            (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         fired <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (rsp_strobe === 1'b1)
            board.check_result(rsp_ok, rsp_result_channel, rsp_sequence_res,
                               rsp_is_dispatch, rsp_last);
         if (start && busy === 1'b0)
            board.note_request(req_operation, req_channel, req_handler_present,
                               req_pending_mask);
         fired <= start && busy === 1'b0;
         if ((start && busy === 1'b0) || rsp_strobe === 1'b1) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_dma_channel_allocator: errors");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // entered and left at a falling edge; start stays high for a following request
   task automatic send_request(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                               input logic hp, input logic [PEND_W-1:0] mask);
      if (!quiet && $urandom_range(0, 99) < 28) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_operation       <= op;
      req_channel         <= ch;
      req_handler_present <= hp;
      req_pending_mask    <= mask;
      start               <= 1'b1;
      do @(negedge clock); while (!fired);
   endtask

   initial begin
      int                 pick;
      logic [OP_W-1:0]    op;
      logic [CH_W-1:0]    ch;
      board = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: bounds, full map, handler dispatch
      send_request(OP_QUERY, 6'd0, 1'b0, '0);
      send_request(OP_ALLOC_ANY, 6'd0, 1'b0, '0);
      send_request(OP_ALLOC_SPECIFIC, 6'd7, 1'b0, '0);
      send_request(OP_ALLOC_SPECIFIC, 6'd7, 1'b0, '0);
      send_request(OP_ALLOC_SPECIFIC, 6'd8, 1'b0, '0);
      send_request(OP_ALLOC_SPECIFIC, 6'd63, 1'b1, '1);
      send_request(OP_FREE, 6'd63, 1'b0, '0);
      send_request(OP_QUERY, 6'd63, 1'b0, '0);
      send_request(OP_SET_HANDLER, 6'd63, 1'b1, '0);
      send_request(OP_SET_HANDLER, 6'd0, 1'b1, '0);
      send_request(OP_SET_HANDLER, 6'd7, 1'b1, '0);
      send_request(OP_INTERRUPT, 6'd0, 1'b0, 32'hFFFF_FFFF);
      send_request(OP_INTERRUPT, 6'd63, 1'b1, 32'hFFFF_FF7E);
      send_request(OP_INTERRUPT, 6'd0, 1'b0, 32'h0000_0000);
      send_request(OP_INTERRUPT, 6'd0, 1'b0, 32'h0000_0081);
      repeat (6) send_request(OP_ALLOC_ANY, 6'd0, 1'b0, '0);
      send_request(OP_ALLOC_ANY, 6'd0, 1'b0, '0);
      send_request(OP_QUERY, 6'd3, 1'b0, '0);
      send_request(OP_FREE, 6'd7, 1'b0, '0);
      send_request(OP_UNUSED_6, 6'd5, 1'b1, '1);
      send_request(OP_UNUSED_7, 6'd63, 1'b0, '1);
      send_request(OP_SET_HANDLER, 6'd0, 1'b0, '0);
      send_request(OP_INTERRUPT, 6'd0, 1'b0, 32'h0000_0081);

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         quiet = (i >= 80 && i < 140);
         pick = $urandom_range(0, 99);
         if (pick < 18)      op = OP_ALLOC_ANY;
         else if (pick < 30) op = OP_ALLOC_SPECIFIC;
         else if (pick < 45) op = OP_FREE;
         else if (pick < 55) op = OP_QUERY;
         else if (pick < 70) op = OP_SET_HANDLER;
         else if (pick < 93) op = OP_INTERRUPT;
         else                op = ($urandom_range(0, 1) != 0) ? OP_UNUSED_7 : OP_UNUSED_6;
         if ($urandom_range(0, 99) < 85) ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
         else                            ch = CH_W'($urandom_range(NUM_CHANNELS, 63));
         send_request(op, ch, $urandom_range(0, 3) != 0, $urandom());
      end
      quiet = 1'b0;
      start <= 1'b0;

      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("tb_dma_channel_allocator: clean");
      end else begin
         $display("tb_dma_channel_allocator: errors");
      end
      $finish;
   end

endmodule
